// ===== rtl/core/mcwk_pkg.sv =====
// ---------------------------------------------------------------------------
// mcwk_pkg
// shared widths, constants and the arctangent table for the wheel kinematics
// ---------------------------------------------------------------------------
package mcwk_pkg;

  localparam int unsigned CordicStagesDefault = 16;
  localparam int unsigned TabLen = 24;
  localparam int unsigned GuardBits = 6;
  localparam logic [15:0] InvGain = 16'd39797;
  localparam logic [15:0] RootHalf = 16'd46341;
  localparam logic [15:0] ArmReset = 16'd256;
  localparam logic [15:0] AngPlus45 = 16'd8192;
  localparam logic [15:0] AngMinus45 = 16'd57344;
  localparam logic [15:0] HalfTurn = 16'd32768;
  localparam int unsigned CompW = 25;   // width of a, b components
  localparam int unsigned CordW = 34;   // cordic x/y width

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    begin
      case (i)
        5'd0: v = 32'h20000000;
        5'd1: v = 32'h12E4051E;
        5'd2: v = 32'h09FB385B;
        5'd3: v = 32'h051111D4;
        5'd4: v = 32'h028B0D43;
        5'd5: v = 32'h0145D7E1;
        5'd6: v = 32'h00A2F61E;
        5'd7: v = 32'h00517C55;
        5'd8: v = 32'h0028BE53;
        5'd9: v = 32'h00145F2F;
        5'd10: v = 32'h000A2F98;
        5'd11: v = 32'h000517CC;
        5'd12: v = 32'h00028BE6;
        5'd13: v = 32'h000145F3;
        5'd14: v = 32'h0000A2F9;
        5'd15: v = 32'h0000517C;
        5'd16: v = 32'h000028BE;
        5'd17: v = 32'h0000145F;
        5'd18: v = 32'h00000A2F;
        5'd19: v = 32'h00000517;
        5'd20: v = 32'h0000028B;
        5'd21: v = 32'h00000145;
        5'd22: v = 32'h000000A2;
        5'd23: v = 32'h00000051;
        default: v = 32'h0;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [CordW+16:0] v);
    logic signed [15:0] r;
    begin
      if (v > (CordW+17)'(32767)) r = 16'sh7FFF;
      else if (v < -(CordW+17)'(32768)) r = 16'sh8000;
      else r = v[15:0];
      return r;
    end
  endfunction

endpackage

// ===== rtl/core/mixed_chassis_wheel_kinematics.sv =====
// ---------------------------------------------------------------------------
// mixed_chassis_wheel_kinematics
// chassis command to omni speeds and steer wheel angle/speed, pipelined cordic
// ---------------------------------------------------------------------------
// channel | direction | ports
// in      | sink      | in_valid, in_ready, in_vel_x .. in_present_angle_right
// out     | source    | out_valid, out_ready, out_speed_*, out_angle_rear_*
// cfg     | sink      | cfg_we, cfg_wdata (arm_length)
//
// one transfer per cycle sustained while out_ready is high; pipeline stages:
// 3 front stages (products, rotate/sum, cordic prep), one stage per
// micro-rotation, two back stages (gain multiply, side choice)
// the whole pipe advances together; a stall at the output freezes every stage
// reset clears valid bits and sets arm_length to 256
module mixed_chassis_wheel_kinematics #(
  parameter int unsigned CORDIC_STAGES = mcwk_pkg::CordicStagesDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_vel_x,
  input  logic signed [15:0] in_vel_y,
  input  logic signed [15:0] in_yaw_rate,
  input  logic [15:0]        in_present_angle_left,
  input  logic [15:0]        in_present_angle_right,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_speed_front_left,
  output logic signed [15:0] out_speed_front_right,
  output logic signed [15:0] out_speed_rear_left,
  output logic signed [15:0] out_speed_rear_right,
  output logic [15:0]        out_angle_rear_left,
  output logic [15:0]        out_angle_rear_right
);

  localparam int unsigned CW = mcwk_pkg::CordW;
  localparam int unsigned AW = mcwk_pkg::CompW;
  localparam int unsigned NS = CORDIC_STAGES;
  localparam int unsigned NP = NS + 5;

  // pipeline advances when the output register is free or being drained
  logic adv;
  logic [NP-1:0] v_r;
  assign adv = !v_r[NP-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = v_r[NP-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NP-2:0], in_valid};
    end
  end

  logic [15:0] arm_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_r <= mcwk_pkg::ArmReset;
    end else if (cfg_we) begin
      arm_r <= cfg_wdata;
    end
  end

  // stage 1: 45 degree rotation products and lever arm product
  logic signed [34:0] pxs_r, pys_r;
  logic signed [33:0] plw_r;
  logic [15:0] nl1_r, nr1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      pxs_r <= 35'(18'(in_vel_x) + 18'(in_vel_y)) * $signed({19'd0, mcwk_pkg::RootHalf});
      pys_r <= 35'(18'(in_vel_y) - 18'(in_vel_x)) * $signed({19'd0, mcwk_pkg::RootHalf});
      plw_r <= $signed({18'd0, arm_r}) * 34'(in_yaw_rate);
      nl1_r <= in_present_angle_left;
      nr1_r <= in_present_angle_right;
    end
  end

  // stage 2: rounding, wheel components and omni speeds
  logic signed [AW-1:0] vxc, vyc, lw;
  logic signed [34:0] pxr, pyr;
  logic signed [33:0] plr;
  assign pxr = pxs_r + 35'sd32768;
  assign pyr = pys_r + 35'sd32768;
  assign plr = plw_r + 34'sd128;
  assign vxc = AW'(pxr >>> 16);
  assign vyc = AW'(pyr >>> 16);
  assign lw  = AW'(plr >>> 8);

  logic signed [AW-1:0] al_r, bl_r, ar_r, br_r;
  logic signed [15:0] sfl_r, sfr_r;
  logic [15:0] nl2_r, nr2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      al_r <= vxc + lw;
      bl_r <= vyc;
      ar_r <= vxc;
      br_r <= vyc - lw;
      sfl_r <= mcwk_pkg::sat16((CW+17)'(lw - vxc));
      sfr_r <= mcwk_pkg::sat16((CW+17)'(vyc + lw));
      nl2_r <= nl1_r;
      nr2_r <= nr1_r;
    end
  end

  // stage 3: case codes and cordic entry (half-plane fold)
  typedef enum logic [1:0] {CASE_ZERO, CASE_AZERO, CASE_BZERO, CASE_GEN} wcase_t;
  typedef struct packed {
    logic [15:0]          now;
    wcase_t               kind;
    logic signed [AW-1:0] a;
    logic signed [AW-1:0] b;
  } side_t;

  function automatic wcase_t kind_of(input logic signed [AW-1:0] a,
                                     input logic signed [AW-1:0] b);
    wcase_t k;
    begin
      if (a == '0 && b == '0) k = CASE_ZERO;
      else if (a == '0) k = CASE_AZERO;
      else if (b == '0) k = CASE_BZERO;
      else k = CASE_GEN;
      return k;
    end
  endfunction

  // per-stage cordic state for both wheels (index 0 left, 1 right)
  logic signed [CW-1:0] cx_r [2][NS+1];
  logic signed [CW-1:0] cy_r [2][NS+1];
  logic [31:0]          cz_r [2][NS+1];
  side_t                cs_r [2][NS+1];
  logic signed [15:0]   f0_r [NS+1];
  logic signed [15:0]   f1_r [NS+1];

  for (genvar w = 0; w < 2; w++) begin : g_entry
    logic signed [AW-1:0] a, b;
    logic signed [CW-1:0] xs, ys;
    assign a = (w == 0) ? al_r : ar_r;
    assign b = (w == 0) ? bl_r : br_r;
    assign xs = CW'(a) <<< mcwk_pkg::GuardBits;
    assign ys = CW'(b) <<< mcwk_pkg::GuardBits;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (a < 0) begin
          cx_r[w][0] <= -xs;
          cy_r[w][0] <= -ys;
          cz_r[w][0] <= 32'h80000000;
        end else begin
          cx_r[w][0] <= xs;
          cy_r[w][0] <= ys;
          cz_r[w][0] <= 32'h0;
        end
        cs_r[w][0] <= '{now: (w == 0) ? nl2_r : nr2_r, kind: kind_of(a, b), a: a, b: b};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f0_r[0] <= sfl_r;
      f1_r[0] <= sfr_r;
    end
  end

  // micro-rotation stages, one register stage each
  for (genvar i = 0; i < NS; i++) begin : g_rot
    localparam int unsigned SH = i;
    for (genvar w = 0; w < 2; w++) begin : g_wheel
      always_ff @(posedge clk) begin
        logic [31:0] at;
        at = (i < mcwk_pkg::TabLen) ? mcwk_pkg::atan_entry(5'(i)) : 32'h0;
        if (adv) begin
          if (i >= mcwk_pkg::TabLen) begin
            cx_r[w][i+1] <= cx_r[w][i];
            cy_r[w][i+1] <= cy_r[w][i];
            cz_r[w][i+1] <= cz_r[w][i];
          end else if (cy_r[w][i] >= 0) begin
            cx_r[w][i+1] <= cx_r[w][i] + (cy_r[w][i] >>> SH);
            cy_r[w][i+1] <= cy_r[w][i] - (cx_r[w][i] >>> SH);
            cz_r[w][i+1] <= cz_r[w][i] + at;
          end else begin
            cx_r[w][i+1] <= cx_r[w][i] - (cy_r[w][i] >>> SH);
            cy_r[w][i+1] <= cy_r[w][i] + (cx_r[w][i] >>> SH);
            cz_r[w][i+1] <= cz_r[w][i] - at;
          end
          cs_r[w][i+1] <= cs_r[w][i];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        f0_r[i+1] <= f0_r[i];
        f1_r[i+1] <= f1_r[i];
      end
    end
  end

  // back stage 1: gain correction multiply, base angle and base speed
  logic [15:0]        bang_r [2];
  logic signed [AW:0] bspd_r [2];
  logic signed [CW+16:0] gm_r [2];
  wcase_t             bk_r [2];
  logic [15:0]        bnow_r [2];
  logic signed [15:0] g0_r, g1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int w = 0; w < 2; w++) begin
        logic [31:0] zr;
        zr = cz_r[w][NS] + 32'h8000;
        gm_r[w] <= (CW+17)'(cx_r[w][NS]) * $signed({1'b0, mcwk_pkg::InvGain});
        bk_r[w] <= cs_r[w][NS].kind;
        bnow_r[w] <= cs_r[w][NS].now;
        case (cs_r[w][NS].kind)
          CASE_AZERO: begin
            bang_r[w] <= mcwk_pkg::AngMinus45;
            bspd_r[w] <= -(AW+1)'(cs_r[w][NS].b);
          end
          CASE_BZERO: begin
            bang_r[w] <= mcwk_pkg::AngPlus45;
            bspd_r[w] <= (AW+1)'(cs_r[w][NS].a);
          end
          CASE_GEN: begin
            bang_r[w] <= zr[31:16] + mcwk_pkg::AngPlus45;
            bspd_r[w] <= '0;
          end
          default: begin
            bang_r[w] <= cs_r[w][NS].now;
            bspd_r[w] <= '0;
          end
        endcase
      end
      g0_r <= f0_r[NS];
      g1_r <= f1_r[NS];
    end
  end

  // back stage 2: pick the side within 90 degrees, saturate, output register
  logic [15:0]        ang_o [2];
  logic signed [15:0] spd_o [2];
  always_comb begin
    for (int w = 0; w < 2; w++) begin
      logic signed [CW+16:0] s, gr;
      logic [15:0] dd;
      logic signed [15:0] d;
      gr = gm_r[w] + ((CW+17)'(1) <<< (15 + mcwk_pkg::GuardBits));
      s = (bk_r[w] == CASE_GEN) ? (gr >>> (16 + mcwk_pkg::GuardBits))
                                : (CW+17)'(bspd_r[w]);
      dd = bnow_r[w] - bang_r[w];
      d = $signed(dd);
      if (bk_r[w] != CASE_ZERO && (d > 16'sd16384 || d < -16'sd16384)) begin
        ang_o[w] = bang_r[w] + mcwk_pkg::HalfTurn;
        s = -s;
      end else begin
        ang_o[w] = bang_r[w];
      end
      spd_o[w] = mcwk_pkg::sat16(s);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_speed_front_left  <= g0_r;
      out_speed_front_right <= g1_r;
      out_speed_rear_left   <= spd_o[0];
      out_speed_rear_right  <= spd_o[1];
      out_angle_rear_left   <= ang_o[0];
      out_angle_rear_right  <= ang_o[1];
    end
  end

endmodule
